// ===== hw/rtl/nwpz_pkg.sv =====
// Package for the W-mass-constrained neutrino pz unit.
// Holds the fixed field widths, saturation codes and the structs that travel down the pipeline.
// Used by neutrino_pz_w_mass_constraint_unit; depends on nothing.
package nwpz_pkg;

    // Fixed-point fraction bits of every momentum field (LSB 1/16 GeV).
    localparam int unsigned FRAC_BITS = 4;

    // Field widths.
    localparam int MOM_W  = 20;
    localparam int ENE_W  = 19;
    localparam int PZ_W   = 20;
    localparam int DOUT_W = 63;

    // Internal widths.
    localparam int K_W    = 42;
    localparam int A_W    = 40;
    localparam int MET_W  = 40;
    localparam int Q4_W   = 84;
    localparam int ROOT_W = 42;
    localparam int REM_W  = 45;
    localparam int KP_W   = 62;
    localparam int NUM_W  = 64;
    localparam int UN_W   = 63;
    localparam int UD_W   = 41;
    localparam int QB     = 21;
    localparam int DM_W   = 122;

    // Saturation codes.
    localparam logic [DOUT_W-1:0] D_POS_MAX  = 63'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [DOUT_W-1:0] D_NEG_CODE = 63'h4000_0000_0000_0000;
    localparam logic [PZ_W-1:0]   PZ_MAX     = 20'h7FFFF;
    localparam logic [PZ_W-1:0]   PZ_MIN     = 20'h80000;

    // Item context carried through the square-root stages.
    typedef struct packed {
        logic signed [KP_W-1:0] kp;
        logic signed [A_W-1:0]  a;
        logic [ENE_W-1:0]       e;
        logic                   other;
        logic                   degen;
        logic                   q4neg;
        logic                   dneg;
        logic [DOUT_W-1:0]      dout;
    } trk_t;

    // Item context carried through the divider stages.
    typedef struct packed {
        logic [UD_W-1:0]   ud;
        logic              neg;
        logic              sat;
        logic              degen;
        logic              dneg;
        logic [DOUT_W-1:0] dout;
    } dv_t;

endpackage

// ===== hw/rtl/neutrino_pz_w_mass_constraint_unit.sv =====
// Top level of the W-mass-constrained neutrino pz unit: a fully pipelined datapath.
// Depends on nwpz_pkg for widths, saturation codes and the pipeline structs.

// The unit takes one lepton plus missing-ET word per clock and returns one result word per
// input word, in order. The pipeline holds eight stages of multiply and add that form the
// quadratic and the discriminant, a 42-stage square root that resolves one root bit per
// stage, three stages that form the root numerator, a 21-stage divider that resolves one
// quotient bit per stage, and an output register. Every stage holds one word, so the
// sustained rate is one word per clock while the output is taken. When the output word is
// not taken the whole pipeline holds and s_axis_tready drops; nothing is lost or repeated.
module neutrino_pz_w_mass_constraint_unit #(
    parameter int unsigned FRAC_BITS = nwpz_pkg::FRAC_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    // lepton_px[19:0], lepton_py[39:20], lepton_pz[59:40], lepton_energy[78:60],
    // lepton_mass[97:79], met_x[117:98], met_y[137:118], zero fill[143:138]
    input  logic [143:0] s_axis_tdata,
    // take_other_root[0]
    input  logic [0:0]   s_axis_tuser,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // neutrino_pz[19:0], discriminant_value[82:20], zero fill[87:83]
    output logic [87:0]  m_axis_tdata,
    // no_real_root[0], degenerate[1]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready
);

    localparam int MOM_W  = nwpz_pkg::MOM_W;
    localparam int ENE_W  = nwpz_pkg::ENE_W;
    localparam int PZ_W   = nwpz_pkg::PZ_W;
    localparam int DOUT_W = nwpz_pkg::DOUT_W;
    localparam int K_W    = nwpz_pkg::K_W;
    localparam int A_W    = nwpz_pkg::A_W;
    localparam int MET_W  = nwpz_pkg::MET_W;
    localparam int Q4_W   = nwpz_pkg::Q4_W;
    localparam int ROOT_W = nwpz_pkg::ROOT_W;
    localparam int REM_W  = nwpz_pkg::REM_W;
    localparam int KP_W   = nwpz_pkg::KP_W;
    localparam int NUM_W  = nwpz_pkg::NUM_W;
    localparam int UN_W   = nwpz_pkg::UN_W;
    localparam int UD_W   = nwpz_pkg::UD_W;
    localparam int QB     = nwpz_pkg::QB;
    localparam int DM_W   = nwpz_pkg::DM_W;

    // W mass squared in LSB^2 units, rounded half up, and the discriminant scale shift.
    localparam logic [63:0] MW_SQ_LSB =
        ((64'd6463999201 << (2 * FRAC_BITS)) + 64'd500000) / 64'd1000000;
    localparam logic signed [K_W-1:0] MW_K = MW_SQ_LSB[K_W-1:0];
    localparam int D_SHIFT = 6 * FRAC_BITS;
    localparam logic [DM_W-1:0] LOW_MASK = ({{(DM_W-1){1'b0}}, 1'b1} << D_SHIFT) - 1'b1;
    localparam logic [DM_W-1:0] D_LIM    = {{(DM_W-1){1'b0}}, 1'b1} << 62;

    localparam int LAT = 8 + ROOT_W + 3 + QB;

    // Global advance: the pipeline moves whenever the output register is free or taken.
    logic adv;
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // Valid bits travel alongside the payload stages.
    logic [LAT-1:0] valid_reg;
    logic           out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= {valid_reg[LAT-2:0], s_axis_tvalid};
            out_valid_reg <= valid_reg[LAT-1];
        end
    end

    // Input field unpacking.
    logic signed [MOM_W-1:0] in_px, in_py, in_pz, in_mx, in_my;
    logic [ENE_W-1:0]        in_e, in_m;

    assign in_px = s_axis_tdata[19:0];
    assign in_py = s_axis_tdata[39:20];
    assign in_pz = s_axis_tdata[59:40];
    assign in_e  = s_axis_tdata[78:60];
    assign in_m  = s_axis_tdata[97:79];
    assign in_mx = s_axis_tdata[117:98];
    assign in_my = s_axis_tdata[137:118];

    // Stage 1: all the input squares and products.
    logic [37:0]               s1_mm_reg, s1_ee_reg;
    logic signed [39:0]        s1_pxmx_reg, s1_pymy_reg;
    logic [38:0]               s1_pzpz_reg, s1_mxmx_reg, s1_mymy_reg;
    logic [ENE_W-1:0]          s1_e_reg;
    logic signed [MOM_W-1:0]   s1_pz_reg;
    logic                      s1_other_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_mm_reg    <= in_m * in_m;
            s1_ee_reg    <= in_e * in_e;
            s1_pxmx_reg  <= in_px * in_mx;
            s1_pymy_reg  <= in_py * in_my;
            s1_pzpz_reg  <= 39'(unsigned'(40'(in_pz * in_pz)));
            s1_mxmx_reg  <= 39'(unsigned'(40'(in_mx * in_mx)));
            s1_mymy_reg  <= 39'(unsigned'(40'(in_my * in_my)));
            s1_e_reg     <= in_e;
            s1_pz_reg    <= in_pz;
            s1_other_reg <= s_axis_tuser[0];
        end
    end

    // Stage 2: the half-constant k (times two), the leading coefficient a and met squared.
    logic signed [K_W-1:0]   s2_k2_reg;
    logic signed [A_W-1:0]   s2_a_reg;
    logic [MET_W-1:0]        s2_met2_reg;
    logic [37:0]             s2_e2_reg;
    logic [ENE_W-1:0]        s2_e_reg;
    logic signed [MOM_W-1:0] s2_pz_reg;
    logic                    s2_other_reg;
    logic signed [K_W-1:0]   s2_dot;

    assign s2_dot = $signed({{2{s1_pxmx_reg[39]}}, s1_pxmx_reg})
                  + $signed({{2{s1_pymy_reg[39]}}, s1_pymy_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_k2_reg    <= MW_K - $signed({4'b0000, s1_mm_reg}) + (s2_dot <<< 1);
            s2_a_reg     <= $signed({2'b00, s1_ee_reg}) - $signed({1'b0, s1_pzpz_reg});
            s2_met2_reg  <= {1'b0, s1_mxmx_reg} + {1'b0, s1_mymy_reg};
            s2_e2_reg    <= s1_ee_reg;
            s2_e_reg     <= s1_e_reg;
            s2_pz_reg    <= s1_pz_reg;
            s2_other_reg <= s1_other_reg;
        end
    end

    // Stage 3: partial products of (2k)^2 and 4|a|*met^2, and 2k*pz.
    logic [K_W-1:0]          s3_kabs;
    logic [UD_W-1:0]         s3_a4;
    logic [62:0]             s3_kk_lo_reg, s3_kk_hi_reg;
    logic [60:0]             s3_am_lo_reg, s3_am_hi_reg;
    logic signed [KP_W-1:0]  s3_kp_reg;
    logic signed [A_W-1:0]   s3_a_reg;
    logic [37:0]             s3_e2_reg;
    logic [ENE_W-1:0]        s3_e_reg;
    logic                    s3_other_reg;
    logic [A_W-1:0]          s3_aabs;

    assign s3_kabs = s2_k2_reg[K_W-1] ? K_W'(-s2_k2_reg) : K_W'(s2_k2_reg);
    assign s3_aabs = s2_a_reg[A_W-1] ? A_W'(-s2_a_reg) : A_W'(s2_a_reg);
    assign s3_a4   = {s3_aabs[38:0], 2'b00};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_kk_lo_reg <= s3_kabs[20:0] * s3_kabs;
            s3_kk_hi_reg <= s3_kabs[41:21] * s3_kabs;
            s3_am_lo_reg <= s3_a4 * s2_met2_reg[19:0];
            s3_am_hi_reg <= s3_a4 * s2_met2_reg[39:20];
            s3_kp_reg    <= s2_k2_reg * s2_pz_reg;
            s3_a_reg     <= s2_a_reg;
            s3_e2_reg    <= s2_e2_reg;
            s3_e_reg     <= s2_e_reg;
            s3_other_reg <= s2_other_reg;
        end
    end

    // Stage 4: sum the partial products.
    logic [Q4_W-1:0]         s4_ksq_reg;
    logic [80:0]             s4_am_reg;
    logic signed [KP_W-1:0]  s4_kp_reg;
    logic signed [A_W-1:0]   s4_a_reg;
    logic [37:0]             s4_e2_reg;
    logic [ENE_W-1:0]        s4_e_reg;
    logic                    s4_other_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_ksq_reg   <= {21'd0, s3_kk_lo_reg} + {s3_kk_hi_reg, 21'd0};
            s4_am_reg    <= {20'd0, s3_am_lo_reg} + {s3_am_hi_reg, 20'd0};
            s4_kp_reg    <= s3_kp_reg;
            s4_a_reg     <= s3_a_reg;
            s4_e2_reg    <= s3_e2_reg;
            s4_e_reg     <= s3_e_reg;
            s4_other_reg <= s3_other_reg;
        end
    end

    // Stage 5: reduced discriminant q4 = 4k^2 - 4*a*met^2 as sign and magnitude.
    logic [Q4_W-1:0] s5_q4_next;
    logic            s5_q4neg_next;
    logic [Q4_W-1:0] s5_am_ext;

    assign s5_am_ext = {3'd0, s4_am_reg};

    always_comb
    begin
        s5_q4neg_next = 1'b0;
        if (s4_a_reg > 0)
        begin
            if (s4_ksq_reg >= s5_am_ext)
            begin
                s5_q4_next = s4_ksq_reg - s5_am_ext;
            end
            else
            begin
                s5_q4_next    = s5_am_ext - s4_ksq_reg;
                s5_q4neg_next = 1'b1;
            end
        end
        else if (s4_a_reg < 0)
        begin
            s5_q4_next = s4_ksq_reg + s5_am_ext;
        end
        else
        begin
            s5_q4_next = s4_ksq_reg;
        end
    end

    logic [Q4_W-1:0]  s5_q4_reg;
    logic [37:0]      s5_e2_reg;
    nwpz_pkg::trk_t   s5_trk_next;
    nwpz_pkg::trk_t   s5_trk_reg;

    // Context that rides along with the discriminant from here on.
    always_comb
    begin
        s5_trk_next.kp    = s4_kp_reg;
        s5_trk_next.a     = s4_a_reg;
        s5_trk_next.e     = s4_e_reg;
        s5_trk_next.other = s4_other_reg;
        s5_trk_next.degen = (s4_a_reg == '0);
        s5_trk_next.q4neg = s5_q4neg_next;
        s5_trk_next.dneg  = 1'b0;
        s5_trk_next.dout  = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_q4_reg  <= s5_q4_next;
            s5_e2_reg  <= s4_e2_reg;
            s5_trk_reg <= s5_trk_next;
        end
    end

    // Stage 6: partial products of the full discriminant E^2 * q4.
    logic [65:0]     s6_p0_reg, s6_p1_reg, s6_p2_reg;
    logic [Q4_W-1:0] s6_q4_reg;
    nwpz_pkg::trk_t  s6_trk_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_p0_reg  <= s5_q4_reg[27:0] * s5_e2_reg;
            s6_p1_reg  <= s5_q4_reg[55:28] * s5_e2_reg;
            s6_p2_reg  <= s5_q4_reg[83:56] * s5_e2_reg;
            s6_q4_reg  <= s5_q4_reg;
            s6_trk_reg <= s5_trk_reg;
        end
    end

    // Stage 7: full discriminant magnitude.
    logic [DM_W-1:0] s7_dm_reg;
    logic [Q4_W-1:0] s7_q4_reg;
    nwpz_pkg::trk_t  s7_trk_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_dm_reg  <= {56'd0, s6_p0_reg} + {28'd0, s6_p1_reg, 28'd0}
                        + {s6_p2_reg, 56'd0};
            s7_q4_reg  <= s6_q4_reg;
            s7_trk_reg <= s6_trk_reg;
        end
    end

    // Stage 8: scale to whole GeV, floor toward minus infinity, saturate.
    logic [DM_W-1:0]   s8_sh, s8_mag;
    logic              s8_lost, s8_dneg;
    logic [DOUT_W-1:0] s8_dout;
    nwpz_pkg::trk_t    s8_trk_next;

    assign s8_sh   = s7_dm_reg >> D_SHIFT;
    assign s8_lost = |(s7_dm_reg & LOW_MASK);
    assign s8_mag  = s8_sh + {{(DM_W-1){1'b0}}, s8_lost};
    assign s8_dneg = s7_trk_reg.q4neg && (s7_dm_reg != '0);

    always_comb
    begin
        if (s8_dneg)
        begin
            s8_dout = (s8_mag > D_LIM) ? nwpz_pkg::D_NEG_CODE : -s8_mag[DOUT_W-1:0];
        end
        else
        begin
            s8_dout = (s8_sh > {59'd0, nwpz_pkg::D_POS_MAX}) ? nwpz_pkg::D_POS_MAX
                                                             : s8_sh[DOUT_W-1:0];
        end
    end

    // The context picks up the discriminant sign and output value.
    always_comb
    begin
        s8_trk_next      = s7_trk_reg;
        s8_trk_next.dneg = s8_dneg;
        s8_trk_next.dout = s8_dout;
    end

    logic [Q4_W-1:0] s8_q4_reg;
    nwpz_pkg::trk_t  s8_trk_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s8_q4_reg  <= s7_q4_reg;
            s8_trk_reg <= s8_trk_next;
        end
    end

    // Square root of q4, one root bit per stage, restoring digit recurrence.
    logic [Q4_W-1:0]   sq_x_reg    [ROOT_W];
    logic [REM_W-1:0]  sq_rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] sq_root_reg [ROOT_W];
    nwpz_pkg::trk_t    sq_trk_reg  [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_sqrt
        logic [Q4_W-1:0]   x_in;
        logic [REM_W-1:0]  rem_in, rem_sh, trial, rem_next;
        logic [ROOT_W-1:0] root_in, root_next;
        nwpz_pkg::trk_t    trk_in;

        if (i == 0)
        begin : g_first
            assign x_in    = s8_q4_reg;
            assign rem_in  = '0;
            assign root_in = '0;
            assign trk_in  = s8_trk_reg;
        end
        else
        begin : g_next
            assign x_in    = sq_x_reg[i-1];
            assign rem_in  = sq_rem_reg[i-1];
            assign root_in = sq_root_reg[i-1];
            assign trk_in  = sq_trk_reg[i-1];
        end

        assign rem_sh = {rem_in[REM_W-3:0], x_in[Q4_W-1:Q4_W-2]};
        assign trial  = {1'b0, root_in, 2'b01};

        always_comb
        begin
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_x_reg[i]    <= {x_in[Q4_W-3:0], 2'b00};
                sq_rem_reg[i]  <= rem_next;
                sq_root_reg[i] <= root_next;
                sq_trk_reg[i]  <= trk_in;
            end
        end
    end

    // Numerator stage 1: E times the root, in two partial products.
    logic [39:0]       e1_lo_reg, e1_hi_reg;
    logic              e1_espos_reg;
    nwpz_pkg::trk_t    e1_trk_reg;
    logic [ROOT_W-1:0] root_fin;
    nwpz_pkg::trk_t    trk_fin;

    assign root_fin = sq_root_reg[ROOT_W-1];
    assign trk_fin  = sq_trk_reg[ROOT_W-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_lo_reg    <= trk_fin.e * root_fin[20:0];
            e1_hi_reg    <= trk_fin.e * root_fin[41:21];
            e1_espos_reg <= !trk_fin.q4neg && (trk_fin.e != '0) && (root_fin != '0);
            e1_trk_reg   <= trk_fin;
        end
    end

    // Numerator stage 2: pick the root and form 2k*pz -+ E*S.
    logic [60:0]              e2_es;
    logic signed [NUM_W-1:0]  e2_kp_ext, e2_es_ext;
    logic                     e2_take_minus;
    logic signed [NUM_W-1:0]  e2_num_reg;
    nwpz_pkg::trk_t           e2_trk_reg;

    assign e2_es         = e1_trk_reg.q4neg ? '0
                         : ({21'd0, e1_lo_reg} + {e1_hi_reg, 21'd0});
    assign e2_kp_ext     = {{(NUM_W-KP_W){e1_trk_reg.kp[KP_W-1]}}, e1_trk_reg.kp};
    assign e2_es_ext     = $signed({3'b000, e2_es});
    assign e2_take_minus = ((e1_trk_reg.kp > 0) && e1_espos_reg) != e1_trk_reg.other;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e2_num_reg <= e2_take_minus ? (e2_kp_ext - e2_es_ext) : (e2_kp_ext + e2_es_ext);
            e2_trk_reg <= e1_trk_reg;
        end
    end

    // Numerator stage 3: magnitudes, quotient sign and the early overflow test.
    logic [UN_W-1:0] e3_un;
    logic [UD_W-1:0] e3_ud;
    logic [A_W-1:0]  e3_aabs;
    nwpz_pkg::dv_t   e3_dv_next;
    logic [UN_W-1:0] e3_rem_reg;
    nwpz_pkg::dv_t   e3_dv_reg;

    assign e3_un   = e2_num_reg[NUM_W-1] ? UN_W'(-e2_num_reg) : UN_W'(e2_num_reg);
    assign e3_aabs = e2_trk_reg.a[A_W-1] ? A_W'(-e2_trk_reg.a) : A_W'(e2_trk_reg.a);
    assign e3_ud   = {e3_aabs, 1'b0};

    // Divider context for this word.
    always_comb
    begin
        e3_dv_next.ud    = e3_ud;
        e3_dv_next.neg   = e2_num_reg[NUM_W-1] != e2_trk_reg.a[A_W-1];
        e3_dv_next.sat   = e3_un >= {1'b0, e3_ud, {QB{1'b0}}};
        e3_dv_next.degen = e2_trk_reg.degen;
        e3_dv_next.dneg  = e2_trk_reg.dneg;
        e3_dv_next.dout  = e2_trk_reg.dout;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e3_rem_reg <= e3_un;
            e3_dv_reg  <= e3_dv_next;
        end
    end

    // Restoring divider, one quotient bit per stage, most significant first.
    logic [UN_W-1:0] dv_rem_reg [QB];
    logic [QB-1:0]   dv_q_reg   [QB];
    nwpz_pkg::dv_t   dv_ctx_reg [QB];

    for (genvar j = 0; j < QB; j++)
    begin : g_div
        localparam int SH = QB - 1 - j;
        logic [UN_W-1:0] rem_in, dsh;
        logic [QB-1:0]   q_in;
        nwpz_pkg::dv_t   ctx_in;

        if (j == 0)
        begin : g_first
            assign rem_in = e3_rem_reg;
            assign q_in   = '0;
            assign ctx_in = e3_dv_reg;
        end
        else
        begin : g_next
            assign rem_in = dv_rem_reg[j-1];
            assign q_in   = dv_q_reg[j-1];
            assign ctx_in = dv_ctx_reg[j-1];
        end

        assign dsh = {{(UN_W-UD_W){1'b0}}, ctx_in.ud} << SH;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (rem_in >= dsh)
                begin
                    dv_rem_reg[j] <= rem_in - dsh;
                    dv_q_reg[j]   <= {q_in[QB-2:0], 1'b1};
                end
                else
                begin
                    dv_rem_reg[j] <= rem_in;
                    dv_q_reg[j]   <= {q_in[QB-2:0], 1'b0};
                end
                dv_ctx_reg[j] <= ctx_in;
            end
        end
    end

    // Output stage: round half away from zero, saturate, apply sign.
    nwpz_pkg::dv_t   fin_ctx;
    logic [QB-1:0]   fin_q;
    logic [UD_W-1:0] fin_r;
    logic            fin_rnd;
    logic [QB:0]     fin_q22;
    logic [PZ_W-1:0] fin_pz;

    assign fin_ctx = dv_ctx_reg[QB-1];
    assign fin_q   = dv_q_reg[QB-1];
    assign fin_r   = dv_rem_reg[QB-1][UD_W-1:0];
    assign fin_rnd = {fin_r, 1'b0} >= {1'b0, fin_ctx.ud};
    assign fin_q22 = {1'b0, fin_q} + {{QB{1'b0}}, fin_rnd};

    always_comb
    begin
        if (fin_ctx.degen)
        begin
            fin_pz = '0;
        end
        else if (fin_ctx.neg)
        begin
            fin_pz = (fin_ctx.sat || (fin_q22 > 22'd524288)) ? nwpz_pkg::PZ_MIN
                                                              : -fin_q22[PZ_W-1:0];
        end
        else
        begin
            fin_pz = (fin_ctx.sat || (fin_q22 > 22'd524287)) ? nwpz_pkg::PZ_MAX
                                                              : fin_q22[PZ_W-1:0];
        end
    end

    logic [PZ_W-1:0]   out_pz_reg;
    logic [DOUT_W-1:0] out_d_reg;
    logic              out_nrr_reg, out_deg_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_pz_reg  <= fin_pz;
            out_d_reg   <= fin_ctx.dout;
            out_nrr_reg <= fin_ctx.dneg;
            out_deg_reg <= fin_ctx.degen;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_d_reg, out_pz_reg};
    assign m_axis_tuser  = {out_deg_reg, out_nrr_reg};

`ifndef NO_ASSERTIONS
    // A degenerate result always carries a zero pz.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[19:0] == '0)
        else $error("degenerate word with nonzero pz");

    // No real root means the reported discriminant is negative.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[82])
        else $error("no_real_root with non-negative discriminant");

    // A zero leading coefficient never gives a negative discriminant.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
        else $error("degenerate and no_real_root together");

    // While the output stalls, the in-flight valid bits hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_reg) && $stable(out_valid_reg))
        else $error("pipeline moved during a stall");
`endif

endmodule

// ===== dv/neutrino_pz_w_mass_constraint_unit_tb.sv =====
// Testbench for neutrino_pz_w_mass_constraint_unit: directed and random lepton/MET words,
// checked against a self-contained predictor of the W mass constraint solution.
// Depends on nwpz_pkg and the unit RTL only.
`timescale 1ns / 1ps

module neutrino_pz_w_mass_constraint_unit_tb;

    localparam int unsigned FRAC_BITS = nwpz_pkg::FRAC_BITS;
    localparam int MOM_W  = nwpz_pkg::MOM_W;
    localparam int ENE_W  = nwpz_pkg::ENE_W;
    localparam int PZ_W   = nwpz_pkg::PZ_W;
    localparam int DOUT_W = nwpz_pkg::DOUT_W;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 120;

    typedef struct {
        logic signed [MOM_W-1:0] px;
        logic signed [MOM_W-1:0] py;
        logic signed [MOM_W-1:0] pz;
        logic [ENE_W-1:0]        e;
        logic [ENE_W-1:0]        m;
        logic signed [MOM_W-1:0] mx;
        logic signed [MOM_W-1:0] my;
        logic                    other;
    } lepton_t;

    typedef struct {
        logic [PZ_W-1:0]   pz;
        logic [DOUT_W-1:0] disc;
        logic              no_root;
        logic              degen;
    } solution_t;

    logic         clk;
    logic         rst_n;
    logic [143:0] s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [87:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;

    solution_t pending_solutions[$];
    int        mismatches  = 0;
    int        idle_cycles = 0;
    bit        idling_on;
    bit        hold_request;
    bit        timed_out   = 1'b0;

    neutrino_pz_w_mass_constraint_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    // Clock with a 10 ns period.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Integer square root, floor, of a non-negative 128-bit value below 2^90.
    function automatic logic [127:0] isqrt128(input logic [127:0] x);
        logic [127:0] r;
        logic [127:0] t;
        r = '0;
        for (int b = 44; b >= 0; b--)
        begin
            t = r | (128'd1 << b);
            if (t * t <= x)
                r = t;
        end
        return r;
    endfunction

    // Divide with rounding to nearest, ties away from zero, saturated to the pz range.
    function automatic logic [PZ_W-1:0] round_div_sat(input logic signed [127:0] n,
                                                      input logic signed [127:0] d);
        logic [127:0] un;
        logic [127:0] ud;
        logic [127:0] q;
        logic [127:0] r;
        logic         neg;
        un  = (n < 0) ? -n : n;
        ud  = (d < 0) ? -d : d;
        q   = un / ud;
        r   = un % ud;
        neg = (n < 0) != (d < 0);
        if (r >= ud - r)
            q = q + 128'd1;
        if (neg)
            return (q > 128'd524288) ? nwpz_pkg::PZ_MIN : PZ_W'(-q);
        return (q > 128'd524287) ? nwpz_pkg::PZ_MAX : PZ_W'(q);
    endfunction

    // Solve the W mass constraint quadratic for one lepton and MET word.
    function automatic solution_t solve_neutrino_pz(input lepton_t l);
        solution_t           s;
        longint              mw_sq;
        longint              k2;
        longint              a;
        longint              met2;
        longint              ee;
        logic signed [127:0] q4;
        logic signed [127:0] d;
        logic signed [127:0] dsh;
        logic signed [127:0] kp;
        logic signed [127:0] es;
        logic signed [127:0] num;
        bit                  minus_smaller;
        mw_sq = ((64'd6463999201 << (2 * FRAC_BITS)) + 64'd500000) / 64'd1000000;
        ee    = longint'(l.e) * longint'(l.e);
        k2    = mw_sq - longint'(l.m) * longint'(l.m)
                + 2 * (longint'(l.px) * longint'(l.mx) + longint'(l.py) * longint'(l.my));
        a     = ee - longint'(l.pz) * longint'(l.pz);
        met2  = longint'(l.mx) * longint'(l.mx) + longint'(l.my) * longint'(l.my);
        q4    = 128'(k2) * 128'(k2) - 128'(4) * 128'(a) * 128'(met2);
        d     = 128'(ee) * q4;
        dsh   = d >>> (6 * FRAC_BITS);
        if (dsh > 128'sh3FFF_FFFF_FFFF_FFFF)
            s.disc = nwpz_pkg::D_POS_MAX;
        else if (dsh < -128'sh4000_0000_0000_0000)
            s.disc = nwpz_pkg::D_NEG_CODE;
        else
            s.disc = dsh[DOUT_W-1:0];
        s.no_root = (d < 0);
        s.degen   = (a == 0);
        kp        = 128'(k2) * 128'(longint'(l.pz));
        if (s.degen)
            s.pz = '0;
        else if (s.no_root)
            s.pz = round_div_sat(kp, 128'(2 * a));
        else
        begin
            es            = (q4 < 0) ? 128'sd0 : 128'(l.e) * $signed(isqrt128(q4));
            minus_smaller = (kp > 0) && (es > 0);
            num           = (minus_smaller != l.other) ? kp - es : kp + es;
            s.pz          = round_div_sat(num, 128'(2 * a));
        end
        return s;
    endfunction

    // Offer one word to the unit, with an optional idle burst first.
    task automatic send_word(input lepton_t l);
        if (idling_on && ($urandom_range(0, 3) == 0))
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        s_axis_tdata  <= {6'b0, l.my, l.mx, l.m, l.e, l.pz, l.py, l.px};
        s_axis_tuser  <= l.other;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_solutions.push_back(solve_neutrino_pz(l));
        @(negedge clk);
    endtask

    function automatic lepton_t random_lepton(input bit physical);
        lepton_t l;
        l.px    = MOM_W'($urandom);
        l.py    = MOM_W'($urandom);
        l.pz    = MOM_W'($urandom);
        l.e     = ENE_W'($urandom);
        l.m     = ENE_W'($urandom);
        l.mx    = MOM_W'($urandom);
        l.my    = MOM_W'($urandom);
        l.other = 1'($urandom);
        // Collider-like kinematics: modest momenta and energy at least |pz|.
        if (physical)
        begin
            l.px = MOM_W'($signed($urandom_range(0, 4000)) - 2000);
            l.py = MOM_W'($signed($urandom_range(0, 4000)) - 2000);
            l.pz = MOM_W'($signed($urandom_range(0, 16000)) - 8000);
            l.mx = MOM_W'($signed($urandom_range(0, 4000)) - 2000);
            l.my = MOM_W'($signed($urandom_range(0, 4000)) - 2000);
            l.m  = ENE_W'($urandom_range(0, 3));
            l.e  = ENE_W'((l.pz < 0 ? -l.pz : l.pz) + $urandom_range(0, 4000));
        end
        return l;
    endfunction

    function automatic lepton_t make_lepton(input int px, input int py, input int pz,
                                            input int e, input int m, input int mx,
                                            input int my, input bit other);
        lepton_t l;
        l.px    = MOM_W'(px);
        l.py    = MOM_W'(py);
        l.pz    = MOM_W'(pz);
        l.e     = ENE_W'(e);
        l.m     = ENE_W'(m);
        l.mx    = MOM_W'(mx);
        l.my    = MOM_W'(my);
        l.other = other;
        return l;
    endfunction

    // Field extremes, both root choices, no real root, degenerate and saturation cases.
    task automatic test_directed();
        send_word(make_lepton(0, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_lepton(524287, 524287, 524287, 524287, 524287, 524287, 524287, 1));
        send_word(make_lepton(-524288, -524288, -524288, 0, 0, -524288, -524288, 0));
        send_word(make_lepton(-524288, 524287, -524288, 524287, 0, 524287, -524288, 1));
        send_word(make_lepton(640, 0, 800, 1024, 0, 500, 0, 0));
        send_word(make_lepton(640, 0, 800, 1024, 0, 500, 0, 1));
        send_word(make_lepton(640, 0, -800, 1024, 0, 500, 0, 0));
        send_word(make_lepton(640, 0, -800, 1024, 0, 500, 0, 1));
        // Leading coefficient zero: energy equals |pz|.
        send_word(make_lepton(100, 50, 1600, 1600, 0, 300, 200, 0));
        send_word(make_lepton(100, 50, -1600, 1600, 0, 300, 200, 1));
        // Negative discriminant: large MET against the lepton.
        send_word(make_lepton(800, 0, 400, 900, 0, -8000, 0, 0));
        send_word(make_lepton(0, 800, -400, 900, 0, 0, -9000, 1));
        // Energy below |pz| gives a negative leading coefficient.
        send_word(make_lepton(300, 300, 5000, 100, 0, 300, 300, 0));
        send_word(make_lepton(300, 300, 5000, 100, 0, 300, 300, 1));
        // Saturation of pz and discriminant.
        send_word(make_lepton(524287, 524287, 524287, 524286, 524287, 524287, 524287, 0));
        send_word(make_lepton(0, 0, 100, 101, 0, 0, 0, 0));
        send_word(make_lepton(0, 0, -100, 101, 0, 0, 0, 1));
        send_word(make_lepton(0, 0, 0, 524287, 524287, 0, 0, 0));
        send_word(make_lepton(1, -1, 2, 3, 1, -1, 1, 1));
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_word(random_lepton($urandom_range(0, 2) != 0));
    endtask

    // The receiver holds off long enough for the pipeline to fill and stall the input.
    task automatic test_backpressure();
        hold_request = 1'b1;
        for (int i = 0; i < 150; i++)
            send_word(random_lepton(1'b1));
    endtask

    task automatic test_back_to_back(input int count);
        idling_on = 1'b0;
        for (int i = 0; i < count; i++)
            send_word(random_lepton($urandom_range(0, 1) != 0));
    endtask

    // Receiver ready with random stall bursts and one long hold-off on request.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_request = 1'b0;
            end
            else if (idling_on && ($urandom_range(0, 5) == 0))
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Compare every accepted result word with the oldest expected solution.
    always @(posedge clk)
    begin
        solution_t exp_s;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_solutions.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word: tdata=%h tuser=%b",
                             m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                exp_s = pending_solutions.pop_front();
                if (m_axis_tdata[19:0] !== exp_s.pz || m_axis_tdata[82:20] !== exp_s.disc
                    || m_axis_tuser[0] !== exp_s.no_root || m_axis_tuser[1] !== exp_s.degen)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch: pz exp %h got %h, disc exp %h got %h, ",
                                  "nrr exp %b got %b, deg exp %b got %b"},
                                 exp_s.pz, m_axis_tdata[19:0], exp_s.disc, m_axis_tdata[82:20],
                                 exp_s.no_root, m_axis_tuser[0], exp_s.degen, m_axis_tuser[1]);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
            timed_out <= 1'b1;
    end

    initial
    begin
        @(posedge timed_out);
        $display("neutrino_pz_w_mass_constraint_unit test failed");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tvalid = 1'b0;
        idling_on     = 1'b1;
        hold_request  = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(600);
        test_backpressure();
        test_back_to_back(150);
        s_axis_tvalid <= 1'b0;

        // Drain the pipeline, then allow for its latency.
        while (pending_solutions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("neutrino_pz_w_mass_constraint_unit test passed");
        else
            $display("neutrino_pz_w_mass_constraint_unit test failed");
        $finish;
    end

endmodule
